>>> hdl/psdd_pkg.sv
// Shared types and constants for the PS/2 device detect sequencer.
`timescale 1ns / 1ps
package psdd_pkg;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TICK    = 2'd2,
    OP_TX_FAIL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_DONE = 2'd1,
    KIND_PASS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TIMEOUT   = 2'd1,
    ST_BAD_RESET = 2'd2,
    ST_TX_ERROR  = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RESET   = 3'd1,
    PH_DRAIN   = 3'd2,
    PH_DISABLE = 3'd3,
    PH_IDACK   = 3'd4,
    PH_IDBYTES = 3'd5,
    PH_ENABLE  = 3'd6
  } phase_e;

  localparam logic [2:0] CFG_TIMEOUT  = 3'd0;
  localparam logic [2:0] CFG_RESET    = 3'd1;
  localparam logic [2:0] CFG_DISABLE  = 3'd2;
  localparam logic [2:0] CFG_IDENTIFY = 3'd3;
  localparam logic [2:0] CFG_ENABLE   = 3'd4;

  localparam logic [7:0] RESP_ACK      = 8'hFA;
  localparam logic [7:0] RESP_SELFTEST = 8'hAA;
  localparam logic [7:0] ID_MOUSE_STD  = 8'h00;
  localparam logic [7:0] ID_MOUSE_WHL  = 8'h03;
  localparam logic [7:0] ID_MOUSE_5BTN = 8'h04;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  reset_cmd;
    logic [7:0]  disable_cmd;
    logic [7:0]  identify_cmd;
    logic [7:0]  enable_cmd;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       is_ack;
    logic       is_selftest;
    logic       is_mouse_id;
  } evt_t;

endpackage

>>> hdl/ps2_device_detect_sequencer.sv
// Top level of the PS/2 device detect sequencer.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   in       | in_valid_i/in_ready_o | operation_i, data_byte_i
//   out      | out_valid_o/out_ready_i | kind_o, out_byte_o, status_o, device_type_o
//   cfg      | cfg_we_i              | cfg_index_i, cfg_data_i
//
// One event per clock unless a result waits on out_ready_i: a beat is queued when
// accepted; the sequencer pops it and registers its result beat at the output.
// The two-entry event queue holds up to two beats while a result waits on
// out_ready_i; in_ready_o drops while the queue is full.
// Reset empties the queue, idles the sequencer and loads the default commands.
`timescale 1ns / 1ps
module ps2_device_detect_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  status_o,
  output logic        device_type_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import psdd_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic q_full;
  logic q_push;
  evt_t q_in_evt;
  logic q_pop;
  logic q_valid;
  evt_t q_out_evt;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT:  cfg_d.timeout_ticks = cfg_data_i;
        CFG_RESET:    cfg_d.reset_cmd     = cfg_data_i[7:0];
        CFG_DISABLE:  cfg_d.disable_cmd   = cfg_data_i[7:0];
        CFG_IDENTIFY: cfg_d.identify_cmd  = cfg_data_i[7:0];
        CFG_ENABLE:   cfg_d.enable_cmd    = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= 16'd1000;
      cfg_q.reset_cmd     <= 8'hFF;
      cfg_q.disable_cmd   <= 8'hF5;
      cfg_q.identify_cmd  <= 8'hF2;
      cfg_q.enable_cmd    <= 8'hF4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  psdd_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_evt_o     (q_in_evt)
  );

  psdd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_evt_i (q_in_evt),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_evt_o  (q_out_evt)
  );

  psdd_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .evt_valid_i   (q_valid),
    .evt_i         (q_out_evt),
    .evt_pop_o     (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .device_type_o (device_type_o)
  );

endmodule

>>> hdl/psdd_front.sv
// Front end: takes input beats and decodes them into classified events.
`timescale 1ns / 1ps
module psdd_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        data_byte_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output psdd_pkg::evt_t    q_evt_o
);
  import psdd_pkg::*;

  assign in_ready_o = ~q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  always_comb begin
    q_evt_o.op          = op_e'(operation_i);
    q_evt_o.data        = data_byte_i;
    q_evt_o.is_ack      = (data_byte_i == RESP_ACK);
    q_evt_o.is_selftest = (data_byte_i == RESP_SELFTEST);
    q_evt_o.is_mouse_id = (data_byte_i == ID_MOUSE_STD) || (data_byte_i == ID_MOUSE_WHL) ||
                          (data_byte_i == ID_MOUSE_5BTN);
  end

endmodule

>>> hdl/psdd_queue.sv
// Short event queue between the front end and the sequencer.
`timescale 1ns / 1ps
module psdd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  psdd_pkg::evt_t push_evt_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output psdd_pkg::evt_t pop_evt_o
);
  import psdd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  evt_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntW'(QueueDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_evt_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(QueueDepth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_evt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> hdl/psdd_seq.sv
// Back end: bring-up state machine and registered result beat.
`timescale 1ns / 1ps
module psdd_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psdd_pkg::cfg_t cfg_i,
  input  logic           evt_valid_i,
  input  psdd_pkg::evt_t evt_i,
  output logic           evt_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [7:0]     out_byte_o,
  output logic [1:0]     status_o,
  output logic           device_type_o
);
  import psdd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [1:0]  reply_q, reply_d;
  logic        ack_seen_q, ack_seen_d;
  logic        st_seen_q, st_seen_d;
  logic        first_mouse_q, first_mouse_d;
  stat_e       pend_q, pend_d;
  logic        found_q, found_d;

  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  stat_e       stat_q, stat_d;
  logic        type_q, type_d;

  logic        pop;
  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic        expired;
  logic        fin;
  stat_e       fin_st;
  logic        go_en;
  stat_e       go_st;
  logic        send;
  logic [7:0]  send_byte;
  logic        pass;
  logic [1:0]  reply_inc;

  assign pop       = evt_valid_i & (~out_valid_q | out_ready_i);
  assign evt_pop_o = pop;

  assign limit     = (cfg_i.timeout_ticks == '0) ? 16'd1 : cfg_i.timeout_ticks;
  assign tick_inc  = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
  assign expired   = (tick_inc >= limit);
  assign reply_inc = reply_q + 2'd1;

  always_comb begin
    phase_d       = phase_q;
    tick_d        = tick_q;
    reply_d       = reply_q;
    ack_seen_d    = ack_seen_q;
    st_seen_d     = st_seen_q;
    first_mouse_d = first_mouse_q;
    pend_d        = pend_q;
    found_d       = found_q;
    fin           = 1'b0;
    fin_st        = ST_OK;
    go_en         = 1'b0;
    go_st         = ST_OK;
    send          = 1'b0;
    send_byte     = '0;
    pass          = 1'b0;

    if (pop) begin
      unique case (phase_q)
        PH_RESET: begin
          priority case (evt_i.op)
            OP_BYTE: begin
              tick_d = '0;
              if (evt_i.is_ack && ack_seen_q) begin
                fin    = 1'b1;
                fin_st = ST_BAD_RESET;
              end else if (evt_i.is_selftest && st_seen_q) begin
                fin    = 1'b1;
                fin_st = ST_BAD_RESET;
              end else begin
                if (evt_i.is_ack) ack_seen_d = 1'b1;
                if (evt_i.is_selftest) st_seen_d = 1'b1;
                reply_d = reply_inc;
                if (reply_inc >= 2'd2) begin
                  phase_d = PH_DRAIN;
                  reply_d = '0;
                end
              end
            end
            OP_TICK: begin
              tick_d = tick_inc;
              if (expired) begin
                fin    = 1'b1;
                fin_st = ST_TIMEOUT;
              end
            end
            OP_TX_FAIL: begin
              fin    = 1'b1;
              fin_st = ST_TX_ERROR;
            end
            default: ;
          endcase
        end
        PH_DRAIN: begin
          if (evt_i.op == OP_BYTE) begin
            tick_d = '0;
          end else if (evt_i.op == OP_TICK) begin
            tick_d = tick_inc;
            if (expired) begin
              phase_d   = PH_DISABLE;
              tick_d    = '0;
              send      = 1'b1;
              send_byte = cfg_i.disable_cmd;
            end
          end
        end
        PH_DISABLE: begin
          priority case (evt_i.op)
            OP_BYTE: begin
              found_d = 1'b0;
              if (evt_i.is_ack) begin
                phase_d   = PH_IDACK;
                tick_d    = '0;
                send      = 1'b1;
                send_byte = cfg_i.identify_cmd;
              end else begin
                go_en = 1'b1;
                go_st = ST_OK;
              end
            end
            OP_TICK: begin
              tick_d = tick_inc;
              if (expired) begin
                go_en = 1'b1;
                go_st = ST_TIMEOUT;
              end
            end
            OP_TX_FAIL: begin
              go_en = 1'b1;
              go_st = ST_TX_ERROR;
            end
            default: ;
          endcase
        end
        PH_IDACK: begin
          if (evt_i.op == OP_TICK) begin
            tick_d = tick_inc;
          end
          if (evt_i.op == OP_BYTE || evt_i.op == OP_TX_FAIL ||
              (evt_i.op == OP_TICK && expired)) begin
            phase_d = PH_IDBYTES;
            reply_d = '0;
            tick_d  = '0;
          end
        end
        PH_IDBYTES: begin
          if (evt_i.op == OP_BYTE) begin
            tick_d = '0;
            if (reply_q == 2'd0) begin
              first_mouse_d = evt_i.is_mouse_id;
              reply_d       = 2'd1;
            end else begin
              reply_d = 2'd2;
              found_d = 1'b0;
              go_en   = 1'b1;
              go_st   = ST_OK;
            end
          end else if (evt_i.op == OP_TICK) begin
            tick_d = tick_inc;
            if (expired) begin
              found_d = (reply_q == 2'd1) && first_mouse_q;
              go_en   = 1'b1;
              go_st   = ST_OK;
            end
          end
        end
        PH_ENABLE: begin
          if (evt_i.op == OP_TICK) begin
            tick_d = tick_inc;
          end
          if (evt_i.op == OP_BYTE || evt_i.op == OP_TX_FAIL ||
              (evt_i.op == OP_TICK && expired)) begin
            fin    = 1'b1;
            fin_st = pend_q;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (evt_i.op == OP_START) begin
            phase_d       = PH_RESET;
            tick_d        = '0;
            reply_d       = '0;
            ack_seen_d    = 1'b0;
            st_seen_d     = 1'b0;
            first_mouse_d = 1'b0;
            pend_d        = ST_OK;
            found_d       = 1'b0;
            send          = 1'b1;
            send_byte     = cfg_i.reset_cmd;
          end else if (evt_i.op == OP_BYTE) begin
            pass = 1'b1;
          end
        end
      endcase

      if (go_en) begin
        pend_d    = go_st;
        phase_d   = PH_ENABLE;
        tick_d    = '0;
        send      = 1'b1;
        send_byte = cfg_i.enable_cmd;
      end
      if (fin) begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    kind_d      = kind_q;
    byte_d      = byte_q;
    stat_d      = stat_q;
    type_d      = type_q;
    if (send || fin || pass) begin
      out_valid_d = 1'b1;
      stat_d      = ST_OK;
      type_d      = 1'b0;
      if (fin) begin
        kind_d = KIND_DONE;
        byte_d = '0;
        stat_d = fin_st;
        type_d = (fin_st == ST_OK) ? found_q : 1'b0;
      end else if (pass) begin
        kind_d = KIND_PASS;
        byte_d = evt_i.data;
      end else begin
        kind_d = KIND_SEND;
        byte_d = send_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      tick_q        <= '0;
      reply_q       <= '0;
      ack_seen_q    <= 1'b0;
      st_seen_q     <= 1'b0;
      first_mouse_q <= 1'b0;
      pend_q        <= ST_OK;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      tick_q        <= tick_d;
      reply_q       <= reply_d;
      ack_seen_q    <= ack_seen_d;
      st_seen_q     <= st_seen_d;
      first_mouse_q <= first_mouse_d;
      pend_q        <= pend_d;
      found_q       <= found_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    stat_q <= stat_d;
    type_q <= type_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign out_byte_o    = byte_q;
  assign status_o      = stat_q;
  assign device_type_o = type_q;

endmodule

>>> sim/ps2_device_detect_sequencer_tb.sv
// Self-checking testbench for the PS/2 device detect sequencer.
`timescale 1ns / 1ps
module ps2_device_detect_sequencer_tb;
  import psdd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned RANDOM_ROUNDS = 10;
  localparam int unsigned ROUND_EVENTS  = 100;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_val;
    stat_e      status;
    logic       dev_type;
  } seq_beat_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  cfg_idx;
    logic [15:0] cfg_val;
    op_e         op;
    logic [7:0]  data;
    bit          typed;
    seq_beat_t   want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = OP_START;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [1:0]  status_o;
  logic        device_type_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = CFG_TIMEOUT;
  logic [15:0] cfg_data_i = 16'h0000;

  seq_beat_t   predicted_beats[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;

  cfg_t        model_cfg;
  phase_e      seq_phase;
  logic [15:0] wait_ticks;
  logic [1:0]  id_count;
  logic        ack_flag;
  logic        selftest_flag;
  logic [7:0]  id_first;
  stat_e       held_status;
  logic        mouse_flag;

  ps2_device_detect_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .device_type_o (device_type_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic seq_beat_t make_beat(kind_e k, logic [7:0] v, stat_e s, logic t);
    seq_beat_t r;
    r.kind = k;
    r.out_val = v;
    r.status = s;
    r.dev_type = t;
    return r;
  endfunction

  function automatic seq_beat_t end_bringup(stat_e s);
    seq_phase = PH_IDLE;
    wait_ticks = '0;
    return make_beat(KIND_DONE, 8'h00, s, (s == ST_OK) ? mouse_flag : 1'b0);
  endfunction

  function automatic seq_beat_t enter_enable(stat_e s);
    held_status = s;
    seq_phase = PH_ENABLE;
    wait_ticks = '0;
    return make_beat(KIND_SEND, model_cfg.enable_cmd, ST_OK, 1'b0);
  endfunction

  function automatic bit wait_expired();
    logic [15:0] lim;
    lim = (model_cfg.timeout_ticks == 16'd0) ? 16'd1 : model_cfg.timeout_ticks;
    if (wait_ticks != 16'hFFFF) wait_ticks = wait_ticks + 16'd1;
    return wait_ticks >= lim;
  endfunction

  function automatic seq_beat_t classify_id();
    mouse_flag = (id_count == 2'd1) &&
                 (id_first == ID_MOUSE_STD || id_first == ID_MOUSE_WHL ||
                  id_first == ID_MOUSE_5BTN);
    return enter_enable(ST_OK);
  endfunction

  function automatic bit advance_sequencer(input op_e op, input logic [7:0] b,
                                           output seq_beat_t r);
    r = '0;
    case (seq_phase)
      PH_RESET: begin
        if (op == OP_BYTE) begin
          wait_ticks = '0;
          if (b == RESP_ACK) begin
            if (ack_flag) begin
              r = end_bringup(ST_BAD_RESET);
              return 1'b1;
            end
            ack_flag = 1'b1;
          end
          if (b == RESP_SELFTEST) begin
            if (selftest_flag) begin
              r = end_bringup(ST_BAD_RESET);
              return 1'b1;
            end
            selftest_flag = 1'b1;
          end
          id_count = id_count + 2'd1;
          if (id_count >= 2'd2) begin
            seq_phase = PH_DRAIN;
            id_count = '0;
          end
          return 1'b0;
        end
        if (op == OP_TICK && wait_expired()) begin
          r = end_bringup(ST_TIMEOUT);
          return 1'b1;
        end
        if (op == OP_TX_FAIL) begin
          r = end_bringup(ST_TX_ERROR);
          return 1'b1;
        end
        return 1'b0;
      end
      PH_DRAIN: begin
        if (op == OP_BYTE) wait_ticks = '0;
        if (op == OP_TICK && wait_expired()) begin
          seq_phase = PH_DISABLE;
          wait_ticks = '0;
          r = make_beat(KIND_SEND, model_cfg.disable_cmd, ST_OK, 1'b0);
          return 1'b1;
        end
        return 1'b0;
      end
      PH_DISABLE: begin
        if (op == OP_BYTE) begin
          mouse_flag = 1'b0;
          if (b == RESP_ACK) begin
            seq_phase = PH_IDACK;
            wait_ticks = '0;
            r = make_beat(KIND_SEND, model_cfg.identify_cmd, ST_OK, 1'b0);
          end else begin
            r = enter_enable(ST_OK);
          end
          return 1'b1;
        end
        if (op == OP_TICK && wait_expired()) begin
          r = enter_enable(ST_TIMEOUT);
          return 1'b1;
        end
        if (op == OP_TX_FAIL) begin
          r = enter_enable(ST_TX_ERROR);
          return 1'b1;
        end
        return 1'b0;
      end
      PH_IDACK: begin
        if (op == OP_BYTE || op == OP_TX_FAIL || (op == OP_TICK && wait_expired())) begin
          seq_phase = PH_IDBYTES;
          id_count = '0;
          wait_ticks = '0;
        end
        return 1'b0;
      end
      PH_IDBYTES: begin
        if (op == OP_BYTE) begin
          wait_ticks = '0;
          if (id_count == 2'd0) begin
            id_first = b;
            id_count = 2'd1;
            return 1'b0;
          end
          id_count = 2'd2;
          r = classify_id();
          return 1'b1;
        end
        if (op == OP_TICK && wait_expired()) begin
          r = classify_id();
          return 1'b1;
        end
        return 1'b0;
      end
      PH_ENABLE: begin
        if (op == OP_BYTE || op == OP_TX_FAIL || (op == OP_TICK && wait_expired())) begin
          r = end_bringup(held_status);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        seq_phase = PH_IDLE;
        if (op == OP_START) begin
          seq_phase = PH_RESET;
          wait_ticks = '0;
          id_count = '0;
          ack_flag = 1'b0;
          selftest_flag = 1'b0;
          id_first = '0;
          held_status = ST_OK;
          mouse_flag = 1'b0;
          r = make_beat(KIND_SEND, model_cfg.reset_cmd, ST_OK, 1'b0);
          return 1'b1;
        end
        if (op == OP_BYTE) begin
          r = make_beat(KIND_PASS, b, ST_OK, 1'b0);
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [7:0] pick_cmd();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return 8'h00;
    if (roll < 4) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void pick_event(output op_e op, output logic [7:0] d);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    d = 8'($urandom_range(0, 255));
    op = OP_TICK;
    case (seq_phase)
      PH_RESET: begin
        if (roll < 4) op = OP_TX_FAIL;
        else if (roll < 12) op = OP_TICK;
        else if (roll < 14) op = OP_START;
        else begin
          op = OP_BYTE;
          roll = $urandom_range(0, 4);
          if (roll < 2) d = RESP_ACK;
          else if (roll < 4) d = RESP_SELFTEST;
        end
      end
      PH_DRAIN: begin
        if (roll < 25) op = OP_BYTE;
        else if (roll < 30) op = OP_TX_FAIL;
        else if (roll < 32) op = OP_START;
      end
      PH_DISABLE: begin
        if (roll < 70) begin
          op = OP_BYTE;
          if ($urandom_range(0, 4) != 0) d = RESP_ACK;
        end else if (roll < 80) op = OP_TICK;
        else if (roll < 88) op = OP_TX_FAIL;
        else op = OP_START;
      end
      PH_IDACK: begin
        if (roll < 40) op = OP_BYTE;
        else if (roll < 75) op = OP_TICK;
        else if (roll < 90) op = OP_TX_FAIL;
        else op = OP_START;
      end
      PH_IDBYTES: begin
        if (roll < 55) begin
          op = OP_BYTE;
          case ($urandom_range(0, 4))
            0: d = ID_MOUSE_STD;
            1: d = ID_MOUSE_WHL;
            2: d = ID_MOUSE_5BTN;
            default: ;
          endcase
        end else if (roll < 92) op = OP_TICK;
        else if (roll < 96) op = OP_TX_FAIL;
        else op = OP_START;
      end
      PH_ENABLE: begin
        if (roll < 40) op = OP_BYTE;
        else if (roll < 70) op = OP_TICK;
        else if (roll < 90) op = OP_TX_FAIL;
        else op = OP_START;
      end
      default: begin
        if (roll < 65) op = OP_START;
        else if (roll < 85) op = OP_BYTE;
        else if (roll < 93) op = OP_TICK;
        else op = OP_TX_FAIL;
      end
    endcase
  endfunction

  function automatic dir_row_t row_event(op_e op, logic [7:0] d);
    dir_row_t r;
    r = '{op: OP_START, default: '0};
    r.op = op;
    r.data = d;
    return r;
  endfunction

  function automatic dir_row_t row_typed(op_e op, logic [7:0] d, kind_e k, logic [7:0] v,
                                         stat_e s, logic t);
    dir_row_t r;
    r = row_event(op, d);
    r.typed = 1'b1;
    r.want = make_beat(k, v, s, t);
    return r;
  endfunction

  function automatic dir_row_t row_write(logic [2:0] idx, logic [15:0] val);
    dir_row_t r;
    r = '{op: OP_START, default: '0};
    r.is_cfg = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  task automatic drive_beat(input op_e op, input logic [7:0] d, input bit typed,
                            input seq_beat_t want, output bit counted);
    phase_e      was;
    seq_beat_t   got;
    bit          has;
    int unsigned gap;
    in_valid_i = 1'b1;
    operation_i = op;
    data_byte_i = d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    was = seq_phase;
    has = advance_sequencer(op, d, got);
    if (typed) predicted_beats.push_back(want);
    else if (has) predicted_beats.push_back(got);
    counted = has || (was != PH_IDLE && op != OP_START &&
              !(op == OP_TX_FAIL && (was == PH_DRAIN || was == PH_IDBYTES)));
    @(negedge clk_i);
    in_valid_i = 1'b0;
    operation_i = 2'($urandom_range(0, 3));
    data_byte_i = 8'($urandom_range(0, 255));
    gap = pick_gap();
    repeat (gap) @(negedge clk_i);
  endtask

  task automatic quiesce();
    in_valid_i = 1'b0;
    while (predicted_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_data_i = 16'($urandom_range(0, 65535));
    case (idx)
      CFG_TIMEOUT:  model_cfg.timeout_ticks = val;
      CFG_RESET:    model_cfg.reset_cmd = val[7:0];
      CFG_DISABLE:  model_cfg.disable_cmd = val[7:0];
      CFG_IDENTIFY: model_cfg.identify_cmd = val[7:0];
      CFG_ENABLE:   model_cfg.enable_cmd = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_random_settings();
    logic [15:0] t;
    int unsigned roll;
    logic [2:0]  spare;
    quiesce();
    roll = $urandom_range(0, 99);
    if (roll < 10) t = 16'd0;
    else if (roll < 75) t = 16'($urandom_range(1, 3));
    else t = 16'($urandom_range(4, 12));
    write_reg(CFG_TIMEOUT, t);
    write_reg(CFG_RESET, {8'($urandom_range(0, 255)), pick_cmd()});
    write_reg(CFG_DISABLE, {8'($urandom_range(0, 255)), pick_cmd()});
    write_reg(CFG_IDENTIFY, {8'($urandom_range(0, 255)), pick_cmd()});
    write_reg(CFG_ENABLE, {8'($urandom_range(0, 255)), pick_cmd()});
    if ($urandom_range(0, 2) == 0) begin
      spare = CFG_ENABLE + 3'($urandom_range(1, 3));
      write_reg(spare, 16'($urandom_range(0, 65535)));
    end
    no_idle = ($urandom_range(0, 4) == 0);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin : check_output
    seq_beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_beats.size() == 0) begin
        $error("unexpected beat: kind %0d out_byte %0h", kind_o, out_byte_o);
        mismatch_count++;
      end else begin
        e = predicted_beats.pop_front();
        if (kind_o != e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind_o);
          mismatch_count++;
        end
        if (out_byte_o != e.out_val) begin
          $error("out_byte: expected %0h, got %0h", e.out_val, out_byte_o);
          mismatch_count++;
        end
        if (status_o != e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          mismatch_count++;
        end
        if (device_type_o != e.dev_type) begin
          $error("device_type: expected %0d, got %0d", e.dev_type, device_type_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : receiver
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i = 1'b1;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    dir_row_t    steps[$];
    seq_beat_t   none;
    op_e         op;
    logic [7:0]  d;
    bit          c;
    int unsigned n_counted;
    none = '0;
    model_cfg = '{16'd1000, 8'hFF, 8'hF5, 8'hF2, 8'hF4};
    seq_phase = PH_IDLE;
    wait_ticks = '0;
    id_count = '0;
    ack_flag = 1'b0;
    selftest_flag = 1'b0;
    id_first = '0;
    held_status = ST_OK;
    mouse_flag = 1'b0;

    steps = '{
      row_typed(OP_BYTE, 8'h00, KIND_PASS, 8'h00, ST_OK, 1'b0),
      row_typed(OP_BYTE, 8'hFF, KIND_PASS, 8'hFF, ST_OK, 1'b0),
      row_event(OP_TICK, 8'h5A),
      row_event(OP_TX_FAIL, 8'hA5),
      row_typed(OP_START, 8'h00, KIND_SEND, 8'hFF, ST_OK, 1'b0),
      row_event(OP_START, 8'h00),
      row_event(OP_BYTE, RESP_ACK),
      row_typed(OP_BYTE, RESP_ACK, KIND_DONE, 8'h00, ST_BAD_RESET, 1'b0),
      row_typed(OP_START, 8'hFF, KIND_SEND, 8'hFF, ST_OK, 1'b0),
      row_typed(OP_TX_FAIL, 8'h00, KIND_DONE, 8'h00, ST_TX_ERROR, 1'b0),
      row_write(CFG_TIMEOUT, 16'd1),
      row_write(CFG_RESET, 16'hFF00),
      row_write(CFG_DISABLE, 16'h00FF),
      row_write(CFG_IDENTIFY, 16'h0000),
      row_write(CFG_ENABLE, 16'hFFFF),
      row_event(OP_START, 8'h00),
      row_typed(OP_TICK, 8'h00, KIND_DONE, 8'h00, ST_TIMEOUT, 1'b0),
      row_event(OP_START, 8'h00),
      row_event(OP_BYTE, RESP_SELFTEST),
      row_event(OP_BYTE, 8'h7E),
      row_event(OP_TX_FAIL, 8'h00),
      row_event(OP_TICK, 8'h00),
      row_event(OP_TX_FAIL, 8'h00),
      row_typed(OP_BYTE, 8'h42, KIND_DONE, 8'h00, ST_TX_ERROR, 1'b0),
      row_event(OP_START, 8'h00),
      row_event(OP_BYTE, RESP_ACK),
      row_event(OP_BYTE, RESP_SELFTEST),
      row_event(OP_TICK, 8'h00),
      row_event(OP_BYTE, RESP_ACK),
      row_event(OP_TICK, 8'h00),
      row_event(OP_BYTE, ID_MOUSE_5BTN),
      row_event(OP_TICK, 8'h00),
      row_event(OP_TX_FAIL, 8'h00)
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        quiesce();
        write_reg(steps[i].cfg_idx, steps[i].cfg_val);
      end else begin
        drive_beat(steps[i].op, steps[i].data, steps[i].typed, steps[i].want, c);
      end
    end

    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      load_random_settings();
      n_counted = 0;
      while (n_counted < ROUND_EVENTS) begin
        pick_event(op, d);
        drive_beat(op, d, 1'b0, none, c);
        if (c) n_counted++;
      end
    end

    no_idle = 1'b0;
    quiesce();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
